@@ hdl/point_in_polygon_test_core_macros.svh @@
// Assertion macros shared by the checker of the point-in-polygon core.
// Needs clk and rst_n in scope where a macro is used.
`ifndef POINT_IN_POLYGON_TEST_CORE_MACROS_SVH
`define POINT_IN_POLYGON_TEST_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PIPT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PIPT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/pipt_pkg.sv @@
// Shared types and constants of the point-in-polygon core.
// No dependencies; used by the sequencer, edge unit, top level and checker.
package pipt_pkg;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam int unsigned VCOUNT_W = 6;
    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 6'd3;
    localparam int unsigned VCOUNT_MIN = 3;
    localparam int unsigned INDEX_W = 5;

    // Sequencer to edge unit
    typedef struct packed {
        logic clear;     // latch query point, clear inside flag
        logic rd_vld;    // vertex read data valid this cycle
        logic rd_first;  // that vertex is the wrap vertex, no edge yet
    } pipt_ctl_t;

    // Edge unit to sequencer
    typedef struct packed {
        logic busy;
        logic parity;
    } pipt_sts_t;

endpackage

@@ hdl/pipt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pipt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/pipt_seq.sv @@
// Sequencer: handshakes, vertex store writes and the per-query address walk.
// Depends on pipt_pkg.
module pipt_seq #(
    parameter int MAX_VERTICES = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 func,
    input  logic [pipt_pkg::INDEX_W-1:0]         vertex_index,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    input  logic [pipt_pkg::VCOUNT_W-1:0]        vertex_count,
    output logic                                 ram_we,
    output logic [$clog2(MAX_VERTICES)-1:0]      ram_waddr,
    output logic                                 ram_re,
    output logic [$clog2(MAX_VERTICES)-1:0]      ram_raddr,
    output pipt_pkg::pipt_ctl_t                  ctl,
    input  pipt_pkg::pipt_sts_t                  sts
);

    localparam int AW    = $clog2(MAX_VERTICES);
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);

    typedef enum logic [1:0] {S_IDLE, S_WALK, S_DRAIN, S_DONE} state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0] last_reg, last_next;
    logic             rd_vld_reg, rd_vld_next;
    logic             rd_first_reg, rd_first_next;

    logic             accept;
    logic             idx_ok;
    logic [31:0]      vc_wide;
    logic [31:0]      n_wide;
    logic [CNT_W-1:0] wrap_idx;
    logic [CNT_W-1:0] prev_idx;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_DONE);
    assign accept    = in_valid & in_ready;

    assign idx_ok    = 32'(vertex_index) < 32'(MAX_VERTICES);
    assign ram_we    = accept && (func == pipt_pkg::FUNC_LOAD) && idx_ok;
    assign ram_waddr = AW'(vertex_index);

    // Clamp the vertex count into the legal range
    assign vc_wide = 32'(vertex_count);
    always_comb
    begin
        priority if (vc_wide < 32'(pipt_pkg::VCOUNT_MIN))
        begin
            n_wide = 32'(pipt_pkg::VCOUNT_MIN);
        end
        else if (vc_wide > 32'(MAX_VERTICES))
        begin
            n_wide = 32'(MAX_VERTICES);
        end
        else
        begin
            n_wide = vc_wide;
        end
    end

    // First read fetches the last vertex, then vertices 0 .. n-1 in turn
    assign wrap_idx  = last_reg - CNT_W'(1);
    assign prev_idx  = step_reg - CNT_W'(1);
    assign ram_re    = (state_reg == S_WALK);
    assign ram_raddr = (step_reg == '0) ? wrap_idx[AW-1:0] : prev_idx[AW-1:0];

    assign ctl.clear    = accept && (func == pipt_pkg::FUNC_QUERY);
    assign ctl.rd_vld   = rd_vld_reg;
    assign ctl.rd_first = rd_first_reg;

    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        last_next     = last_reg;
        rd_vld_next   = (state_reg == S_WALK);
        rd_first_next = (state_reg == S_WALK) && (step_reg == '0);
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (func == pipt_pkg::FUNC_QUERY))
                begin
                    state_next = S_WALK;
                    step_next  = '0;
                    last_next  = n_wide[CNT_W-1:0];
                end
            end
            S_WALK:
            begin
                step_next = step_reg + CNT_W'(1);
                if (step_reg == last_reg)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // wait for the last edge to leave the edge unit
                if (!rd_vld_reg && !sts.busy)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            step_reg     <= '0;
            last_reg     <= '0;
            rd_vld_reg   <= 1'b0;
            rd_first_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            last_reg     <= last_next;
            rd_vld_reg   <= rd_vld_next;
            rd_first_reg <= rd_first_next;
        end
    end

endmodule

@@ hdl/pipt_edge.sv @@
// Shared edge unit: straddle test, cross multiplication and inside flag.
// Three stages per edge: differences, products, compare. Depends on pipt_pkg.
module pipt_edge #(
    parameter int COORD_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  pipt_pkg::pipt_ctl_t          ctl,
    input  logic signed [COORD_BITS-1:0] coord_x,
    input  logic signed [COORD_BITS-1:0] coord_y,
    input  logic [2*COORD_BITS-1:0]      rd_data,
    output pipt_pkg::pipt_sts_t          sts
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;

    logic signed [COORD_BITS-1:0] px_reg, py_reg;
    logic signed [COORD_BITS-1:0] xj_reg, yj_reg;
    logic signed [COORD_BITS-1:0] xi, yi;

    logic                 s1_vld_reg, s1_vld_next;
    logic                 s1_str_reg, s1_dpos_reg;
    logic signed [DW-1:0] a_reg, d_reg, b_reg, c_reg;
    logic                 s2_vld_reg;
    logic                 s2_str_reg, s2_dpos_reg;
    logic signed [PW-1:0] p1_reg, p2_reg;
    logic                 inside_reg, inside_next;

    logic                 straddle;
    logic                 left;
    logic signed [DW-1:0] a_next, d_next, b_next, c_next;
    logic signed [PW-1:0] p1_next, p2_next;

    assign xi = $signed(rd_data[2*COORD_BITS-1:COORD_BITS]);
    assign yi = $signed(rd_data[COORD_BITS-1:0]);

    assign straddle = (yi > py_reg) != (yj_reg > py_reg);
    assign a_next   = $signed({px_reg[COORD_BITS-1], px_reg}) - $signed({xi[COORD_BITS-1], xi});
    assign d_next   = $signed({yj_reg[COORD_BITS-1], yj_reg}) - $signed({yi[COORD_BITS-1], yi});
    assign b_next   = $signed({xj_reg[COORD_BITS-1], xj_reg}) - $signed({xi[COORD_BITS-1], xi});
    assign c_next   = $signed({py_reg[COORD_BITS-1], py_reg}) - $signed({yi[COORD_BITS-1], yi});
    assign s1_vld_next = ctl.rd_vld && !ctl.rd_first;

    assign p1_next = a_reg * d_reg;
    assign p2_next = b_reg * c_reg;

    // d > 0 keeps the sense of the compare, d < 0 flips it
    assign left = s2_dpos_reg ? (p1_reg < p2_reg) : (p2_reg < p1_reg);

    always_comb
    begin
        inside_next = inside_reg;
        priority if (ctl.clear)
        begin
            inside_next = 1'b0;
        end
        else if (s2_vld_reg && s2_str_reg && left)
        begin
            inside_next = !inside_reg;
        end
        else
        begin
            inside_next = inside_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            inside_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= s1_vld_next;
            s2_vld_reg <= s1_vld_reg;
            inside_reg <= inside_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.clear)
        begin
            px_reg <= coord_x;
            py_reg <= coord_y;
        end
        // hold the previous vertex for the next edge
        if (ctl.rd_vld)
        begin
            xj_reg <= xi;
            yj_reg <= yi;
        end
        s1_str_reg  <= straddle;
        s1_dpos_reg <= yj_reg > yi;
        a_reg       <= a_next;
        d_reg       <= d_next;
        b_reg       <= b_next;
        c_reg       <= c_next;
        s2_str_reg  <= s1_str_reg;
        s2_dpos_reg <= s1_dpos_reg;
        p1_reg      <= p1_next;
        p2_reg      <= p2_next;
    end

    assign sts.busy   = s1_vld_reg | s2_vld_reg;
    assign sts.parity = inside_reg;

endmodule

@@ hdl/point_in_polygon_test_core.sv @@
// Even-odd point-in-polygon core. A load beat (func 0) writes one vertex into the
// store and produces no result. A query beat (func 1) walks every edge of the
// polygon (n vertices, vertex_count clamped to 3 .. MAX_VERTICES) and raises out_valid
// with the inside flag. The walk is paced by the single read port of the vertex
// store, which feeds one vertex per cycle (the wrap vertex, then vertices 0 .. n-1)
// into the shared three-stage cross-multiply unit. in_ready is low from a query's
// acceptance until its result is taken. Vertex slots read by a query must have
// been loaded first. vertex_count is written through cfg_wr_en; the user must
// write it only while idle, and the core itself does not enforce this.
// Depends on pipt_pkg, pipt_ram, pipt_seq and pipt_edge.
module point_in_polygon_test_core #(
    parameter int MAX_VERTICES = 32,
    parameter int COORD_BITS   = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [pipt_pkg::VCOUNT_W-1:0]       cfg_wr_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                func,
    input  logic [pipt_pkg::INDEX_W-1:0]        vertex_index,
    input  logic signed [COORD_BITS-1:0]        coord_x,
    input  logic signed [COORD_BITS-1:0]        coord_y,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                inside_res
);

    localparam int AW = $clog2(MAX_VERTICES);

    logic [pipt_pkg::VCOUNT_W-1:0] vertex_count_reg;

    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic                    ram_re;
    logic [AW-1:0]           ram_raddr;
    logic [2*COORD_BITS-1:0] ram_rdata;
    pipt_pkg::pipt_ctl_t     ctl;
    pipt_pkg::pipt_sts_t     sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= pipt_pkg::VCOUNT_RESET;
        end
        else if (cfg_wr_en)
        begin
            vertex_count_reg <= cfg_wr_data;
        end
    end

    pipt_seq #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .vertex_index (vertex_index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .vertex_count (vertex_count_reg),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_re       (ram_re),
        .ram_raddr    (ram_raddr),
        .ctl          (ctl),
        .sts          (sts)
    );

    // x in the upper half, y in the lower half of each word
    pipt_ram #(
        .WIDTH (2 * COORD_BITS),
        .DEPTH (MAX_VERTICES)
    ) u_vertex_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({coord_x, coord_y}),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pipt_edge #(
        .COORD_BITS (COORD_BITS)
    ) u_edge (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .coord_x (coord_x),
        .coord_y (coord_y),
        .rd_data (ram_rdata),
        .sts     (sts)
    );

    assign inside_res = sts.parity;

endmodule

@@ hdl/pipt_checker.sv @@
// Port-level checks of the point-in-polygon core, bound to the top level.
// Depends on pipt_pkg and point_in_polygon_test_core_macros.svh.
`include "point_in_polygon_test_core_macros.svh"

module pipt_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic func,
    input logic out_valid,
    input logic out_ready,
    input logic inside_res
);

    // one item in flight: never take a beat while a result waits
    `PIPT_ASSERT_NOW(a_no_accept_with_result, out_valid, !in_ready, "ready while result pending")

    `PIPT_ASSERT_NEXT(a_query_blocks, in_valid && in_ready && (func == pipt_pkg::FUNC_QUERY), !in_ready && !out_valid, "query did not start its walk")

    `PIPT_ASSERT_NEXT(a_load_silent, in_valid && in_ready && (func == pipt_pkg::FUNC_LOAD), in_ready && !out_valid, "load produced a result")

    `PIPT_ASSERT_NEXT(a_result_holds, out_valid && !out_ready, out_valid && $stable(inside_res), "stalled result changed")

endmodule

bind point_in_polygon_test_core pipt_checker u_pipt_checker (.*);
